FILE: hdl/spend_limit_window_guard_unit_defines.svh
// Assertion macros shared by the spending guard RTL files.
// Included by bare file name; no other dependencies.
`ifndef SPEND_LIMIT_WINDOW_GUARD_UNIT_DEFINES_SVH
`define SPEND_LIMIT_WINDOW_GUARD_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SLWG_ASSERT(lbl, clock, rstn, prop, msg) \
	lbl: assert property (@(posedge clock) disable iff (!(rstn)) (prop)) else $error(msg);
`define SLWG_ASSERT_ALWAYS(lbl, clock, prop, msg) \
	lbl: assert property (@(posedge clock) (prop)) else $error(msg);
`else
`define SLWG_ASSERT(lbl, clock, rstn, prop, msg)
`define SLWG_ASSERT_ALWAYS(lbl, clock, prop, msg)
`endif
`endif

FILE: hdl/slwg_pkg.sv
// Types and constants of the spending guard: operation codes, beat layouts
// and register reset values. No dependencies.
package slwg_pkg;

	typedef enum logic [1:0] {
		MODE_AUTH  = 2'd0,
		MODE_SCHED = 2'd1,
		MODE_QUERY = 2'd2,
		MODE_ROLL  = 2'd3
	} mode_t;

	localparam logic [31:0] SAT_TIME        = 32'hFFFF_FFFF;
	localparam logic [31:0] WINDOW_RESET    = 32'd86400;
	localparam logic [31:0] COOLDOWN_RESET  = 32'd86400;
	localparam logic [2:0]  REG_ADDR_WINDOW = 3'd0;
	localparam logic [2:0]  REG_ADDR_COOL   = 3'd4;

	typedef struct packed {
		logic [63:0] next_budget_cap;
		logic [63:0] next_tx_cap;
		logic [63:0] amount;
		logic [31:0] now;
		mode_t       mode;
	} item_t;

	typedef struct packed {
		logic state_changed;
		logic cooling_down;
		logic approved;
	} result_t;

	typedef struct packed {
		logic [31:0] cooldown_length;
		logic [31:0] window_length;
	} cfg_t;

endpackage

FILE: hdl/slwg_apb_regs.sv
// APB register file of the spending guard: window and cooldown lengths.
// Depends on slwg_pkg.
module slwg_apb_regs (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	output slwg_pkg::cfg_t       cfg
);

	logic [31:0] window_length_q;
	logic [31:0] cooldown_length_q;
	logic        wr_en;
	logic        sel_cool;

	assign pready   = 1'b1;
	assign wr_en    = psel & penable & pwrite;
	assign sel_cool = paddr[2] == slwg_pkg::REG_ADDR_COOL[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q   <= slwg_pkg::WINDOW_RESET;
			cooldown_length_q <= slwg_pkg::COOLDOWN_RESET;
		end else if (wr_en) begin
			if (sel_cool) begin
				cooldown_length_q <= pwdata;
			end else begin
				window_length_q <= pwdata;
			end
		end
	end

	assign prdata              = sel_cool ? cooldown_length_q : window_length_q;
	assign cfg.window_length   = window_length_q;
	assign cfg.cooldown_length = cooldown_length_q;

endmodule

FILE: hdl/slwg_core.sv
// Decision logic and persistent state of the spending guard: activation,
// window roll, approval and scheduling in one pass. Depends on slwg_pkg.
`include "spend_limit_window_guard_unit_defines.svh"
module slwg_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  slwg_pkg::item_t      item,
	input  slwg_pkg::cfg_t       cfg,
	output slwg_pkg::result_t    result
);

	logic [63:0] tx_cap_q;
	logic [63:0] budget_cap_q;
	logic [63:0] pending_tx_cap_q;
	logic [63:0] pending_budget_cap_q;
	logic [31:0] activation_time_q;
	logic [31:0] window_begin_q;
	logic [63:0] budget_spent_q;

	logic        is_auth;
	logic        is_sched;
	logic        activate;
	logic        roll;
	logic        ok;
	logic [63:0] tx_cap_eff;
	logic [63:0] budget_cap_eff;
	logic [63:0] spent_eff;
	logic [63:0] headroom;
	logic [31:0] elapsed;
	logic [32:0] sched_sum;
	logic [31:0] sched_time;
	logic [31:0] act_time_next;

	always_comb begin
		is_auth  = item.mode == slwg_pkg::MODE_AUTH;
		is_sched = item.mode == slwg_pkg::MODE_SCHED;
		activate = is_auth && (activation_time_q != 32'd0)
			&& (item.now >= activation_time_q);
		tx_cap_eff     = activate ? pending_tx_cap_q : tx_cap_q;
		budget_cap_eff = activate ? pending_budget_cap_q : budget_cap_q;
		elapsed = item.now - window_begin_q;
		roll = (is_auth || item.mode == slwg_pkg::MODE_ROLL)
			&& (cfg.window_length != 32'd0) && (elapsed >= cfg.window_length);
		spent_eff = roll ? 64'd0 : budget_spent_q;
		headroom  = budget_cap_eff - spent_eff;
		ok = is_auth && (item.amount <= tx_cap_eff) && (spent_eff <= budget_cap_eff)
			&& (item.amount <= headroom);
		sched_sum  = {1'b0, item.now} + {1'b0, cfg.cooldown_length};
		sched_time = sched_sum[32] ? slwg_pkg::SAT_TIME : sched_sum[31:0];
		if (is_sched) begin
			act_time_next = sched_time;
		end else if (activate) begin
			act_time_next = 32'd0;
		end else begin
			act_time_next = activation_time_q;
		end
		result.approved      = ok;
		result.cooling_down  = (act_time_next != 32'd0) && (item.now < act_time_next);
		result.state_changed = activate | roll | ok | is_sched;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_cap_q             <= '0;
			budget_cap_q         <= '0;
			pending_tx_cap_q     <= '0;
			pending_budget_cap_q <= '0;
			activation_time_q    <= '0;
			window_begin_q       <= '0;
			budget_spent_q       <= '0;
		end else if (fire) begin
			tx_cap_q          <= tx_cap_eff;
			budget_cap_q      <= budget_cap_eff;
			activation_time_q <= act_time_next;
			if (is_sched) begin
				pending_tx_cap_q     <= item.next_tx_cap;
				pending_budget_cap_q <= item.next_budget_cap;
			end
			if (roll) begin
				window_begin_q <= item.now;
			end
			budget_spent_q <= ok ? spent_eff + item.amount : spent_eff;
		end
	end

	`SLWG_ASSERT(a_idle_holds_state, clk, arst_n, !fire |=> $stable(budget_spent_q) && $stable(activation_time_q) && $stable(tx_cap_q), "State changed without an accepted beat.")
	`SLWG_ASSERT(a_activation_clears, clk, arst_n, fire && activate |=> activation_time_q == 32'd0 && tx_cap_q == $past(pending_tx_cap_q), "Activation did not install pending caps.")
	`SLWG_ASSERT(a_approve_auth_only, clk, arst_n, ok |-> is_auth && result.state_changed, "Approval outside an authorize request.")

endmodule

FILE: hdl/spend_limit_window_guard_unit.sv
// Top level of the spending guard: stream input register, decision core and
// result register. Depends on slwg_pkg, slwg_apb_regs and slwg_core.
// The guard takes one request beat per clock cycle unless the result side
// stalls it, and presents exactly one result beat for it (input register, then
// result register), with the decision and all state updates made as the beat
// moves between them. Requests that follow one another each see the state left
// by the previous one. Window and cooldown lengths are set through the APB port
// (window at 0x0, cooldown at 0x4) and should only be written while no request
// is in flight.
`include "spend_limit_window_guard_unit_defines.svh"
module spend_limit_window_guard_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	input  logic         s_tvalid,
	output logic         s_tready,
	// now[31:0], amount[95:32], next_tx_cap[159:96], next_budget_cap[223:160]
	input  logic [223:0] s_tdata,
	// mode[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// approved[0], cooling_down[1], state_changed[2], zero fill[7:3]
	output logic [7:0]   m_tdata
);

	slwg_pkg::cfg_t    cfg;
	slwg_pkg::item_t   item_s1;
	slwg_pkg::result_t result;
	slwg_pkg::result_t result_s2;
	logic              valid_s1;
	logic              valid_s2;
	logic              out_free;
	logic              advance;

	slwg_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign out_free = !valid_s2 || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.mode            <= slwg_pkg::mode_t'(s_tuser);
			item_s1.now             <= s_tdata[31:0];
			item_s1.amount          <= s_tdata[95:32];
			item_s1.next_tx_cap     <= s_tdata[159:96];
			item_s1.next_budget_cap <= s_tdata[223:160];
		end
	end

	slwg_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'd0, result_s2.state_changed, result_s2.cooling_down,
		result_s2.approved};

	`SLWG_ASSERT(a_no_take_when_full, clk, arst_n, valid_s1 && valid_s2 && !m_tready |-> !s_tready, "Input taken while both stages are blocked.")
	`SLWG_ASSERT(a_advance_fills_out, clk, arst_n, advance |=> valid_s2, "Advanced beat did not reach the result register.")
	`SLWG_ASSERT(a_approve_is_change, clk, arst_n, valid_s2 |-> !(result_s2.approved && !result_s2.state_changed), "Approval reported without a state change.")

endmodule

FILE: sim/slwg_checker.sv
`timescale 1ns / 100ps
// Checker for the spending guard: watches the APB port and both stream channels,
// predicts each result beat and compares it field by field. Depends on slwg_pkg.
module slwg_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	input  logic [31:0]  prdata,
	input  logic         pready,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [223:0] s_tdata,
	input  logic [1:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [7:0]   m_tdata,
	output int           fail_count,
	output int           in_flight
);

	logic [31:0]       win_len;
	logic [31:0]       cool_len;
	logic [63:0]       tx_cap;
	logic [63:0]       budget_cap;
	logic [63:0]       next_tx;
	logic [63:0]       next_budget;
	logic [31:0]       act_time;
	logic [31:0]       win_start;
	logic [63:0]       spent;
	slwg_pkg::result_t verdicts[$];
	int                errs = 0;

	function automatic bit roll_window(input logic [31:0] t);
		if (win_len == 32'd0) return 1'b0;
		if (32'(t - win_start) >= win_len) begin
			win_start = t;
			spent = 64'd0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic decide(input logic [1:0] op_bits, input logic [31:0] t,
			input logic [63:0] amt, input logic [63:0] ntx, input logic [63:0] nbc);
		slwg_pkg::result_t r;
		slwg_pkg::mode_t   op;
		op = slwg_pkg::mode_t'(op_bits);
		r = '0;
		case (op)
			slwg_pkg::MODE_AUTH: begin
				if (act_time != 32'd0 && t >= act_time) begin
					tx_cap = next_tx;
					budget_cap = next_budget;
					act_time = 32'd0;
					r.state_changed = 1'b1;
				end
				if (roll_window(t)) r.state_changed = 1'b1;
				if (amt <= tx_cap && spent <= budget_cap && amt <= budget_cap - spent) begin
					spent = spent + amt;
					r.approved = 1'b1;
					r.state_changed = 1'b1;
				end
			end
			slwg_pkg::MODE_SCHED: begin
				next_tx = ntx;
				next_budget = nbc;
				if (cool_len > slwg_pkg::SAT_TIME - t) act_time = slwg_pkg::SAT_TIME;
				else act_time = t + cool_len;
				r.state_changed = 1'b1;
			end
			slwg_pkg::MODE_ROLL: begin
				if (roll_window(t)) r.state_changed = 1'b1;
			end
			default: ;
		endcase
		r.cooling_down = (act_time != 32'd0) && (t < act_time);
		verdicts.push_back(r);
	endtask

	task automatic compare(input logic [7:0] beat);
		slwg_pkg::result_t want;
		if (verdicts.size() == 0) begin
			$error("result beat %h arrived with no request outstanding", beat);
			errs++;
			return;
		end
		want = verdicts.pop_front();
		if (beat[0] !== want.approved) begin
			$error("approved: expected %0b, actual %0b", want.approved, beat[0]);
			errs++;
		end
		if (beat[1] !== want.cooling_down) begin
			$error("cooling_down: expected %0b, actual %0b", want.cooling_down, beat[1]);
			errs++;
		end
		if (beat[2] !== want.state_changed) begin
			$error("state_changed: expected %0b, actual %0b", want.state_changed, beat[2]);
			errs++;
		end
		if (beat[7:3] !== 5'd0) begin
			$error("zero fill: expected 0, actual %h", beat[7:3]);
			errs++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len = slwg_pkg::WINDOW_RESET;
			cool_len = slwg_pkg::COOLDOWN_RESET;
			tx_cap = '0;
			budget_cap = '0;
			next_tx = '0;
			next_budget = '0;
			act_time = '0;
			win_start = '0;
			spent = '0;
			verdicts.delete();
			in_flight <= 0;
			fail_count <= errs;
		end else begin
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr)
						slwg_pkg::REG_ADDR_WINDOW: win_len = pwdata;
						slwg_pkg::REG_ADDR_COOL:   cool_len = pwdata;
						default: ;
					endcase
				end else if (paddr == slwg_pkg::REG_ADDR_WINDOW && prdata !== win_len) begin
					$error("window_length: expected %h, actual %h", win_len, prdata);
					errs++;
				end else if (paddr == slwg_pkg::REG_ADDR_COOL && prdata !== cool_len) begin
					$error("cooldown_length: expected %h, actual %h", cool_len, prdata);
					errs++;
				end
			end
			if (m_tvalid && m_tready) compare(m_tdata);
			if (s_tvalid && s_tready)
				decide(s_tuser, s_tdata[31:0], s_tdata[95:32], s_tdata[159:96],
					s_tdata[223:160]);
			in_flight <= verdicts.size();
			fail_count <= errs;
		end
	end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// Testbench top: clock, reset, request and APB stimulus, result back-pressure
// and the verdict. Uses slwg_pkg, slwg_checker, spend_limit_window_guard_unit.
module tb_top;

	localparam int QUIET_LIMIT = 1000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [2:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	// now[31:0], amount[95:32], next_tx_cap[159:96], next_budget_cap[223:160]
	logic [223:0] s_tdata = '0;
	// mode[1:0]
	logic [1:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	// approved[0], cooling_down[1], state_changed[2], zero fill[7:3]
	logic [7:0]   m_tdata;

	int          errors;
	int          outstanding;
	int          quiet = 0;
	bit          steady = 1'b0;
	logic [31:0] clock_now = '0;
	logic [63:0] last_tx_cap = '0;
	logic [63:0] last_budget_cap = '0;

	always #2 clk = ~clk;

	spend_limit_window_guard_unit uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	slwg_checker guard_chk (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.fail_count(errors), .in_flight(outstanding)
	);

	task automatic push_request(input slwg_pkg::mode_t op, input logic [31:0] t,
			input logic [63:0] amt, input logic [63:0] ntx, input logic [63:0] nbc);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {nbc, ntx, amt, t};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [31:0] win, input logic [31:0] cool);
		drain();
		apb_access(1'b1, slwg_pkg::REG_ADDR_WINDOW, win);
		apb_access(1'b0, slwg_pkg::REG_ADDR_WINDOW, '0);
		apb_access(1'b1, slwg_pkg::REG_ADDR_COOL, cool);
		apb_access(1'b0, slwg_pkg::REG_ADDR_COOL, '0);
	endtask

	function automatic logic [63:0] random_cap();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 80) return 64'($urandom_range(0, 1000));
		if (pick < 95) return {$urandom, $urandom};
		return {64{1'b1}};
	endfunction

	task automatic random_request();
		int              pick;
		slwg_pkg::mode_t op;
		logic [63:0]     amt;
		logic [63:0]     ntx;
		logic [63:0]     nbc;
		pick = $urandom_range(0, 99);
		if (pick < 50) op = slwg_pkg::MODE_AUTH;
		else if (pick < 65) op = slwg_pkg::MODE_SCHED;
		else if (pick < 75) op = slwg_pkg::MODE_QUERY;
		else op = slwg_pkg::MODE_ROLL;
		pick = $urandom_range(0, 99);
		if (pick < 80) clock_now = clock_now + $urandom_range(0, 4);
		else if (pick < 97) clock_now = clock_now + $urandom_range(0, 200);
		else clock_now = $urandom;
		ntx = random_cap();
		nbc = random_cap();
		pick = $urandom_range(0, 99);
		if (pick < 35) amt = 64'($urandom_range(0, 300));
		else if (pick < 45) amt = last_tx_cap;
		else if (pick < 52) amt = last_tx_cap + 64'd1;
		else if (pick < 60) amt = last_budget_cap;
		else if (pick < 78) amt = {$urandom, $urandom};
		else if (pick < 90) amt = '0;
		else amt = {64{1'b1}};
		if (op == slwg_pkg::MODE_SCHED) begin
			last_tx_cap = ntx;
			last_budget_cap = nbc;
		end
		push_request(op, clock_now, amt, ntx, nbc);
	endtask

	initial begin
		int stall;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && !(s_tvalid && s_tready) && !(m_tvalid && m_tready) && !psel)
			quiet = quiet + 1;
		else
			quiet = 0;
		if (quiet >= QUIET_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With reset defaults the caps are zero, so at first only a zero amount passes.
		push_request(slwg_pkg::MODE_AUTH, 32'd0, 64'd0, '0, '0);
		push_request(slwg_pkg::MODE_AUTH, 32'd0, 64'd1, '0, '0);
		push_request(slwg_pkg::MODE_QUERY, 32'd7, '0, '0, '0);
		push_request(slwg_pkg::MODE_ROLL, 32'd86400, '0, '0, '0);
		push_request(slwg_pkg::MODE_SCHED, 32'd100, '0, {64{1'b1}}, {64{1'b1}});
		push_request(slwg_pkg::MODE_QUERY, 32'd100, '0, '0, '0);
		push_request(slwg_pkg::MODE_AUTH, 32'd86499, 64'd1, '0, '0);
		push_request(slwg_pkg::MODE_AUTH, 32'd86500, {64{1'b1}}, '0, '0);
		push_request(slwg_pkg::MODE_AUTH, 32'd86501, 64'd1, '0, '0);
		push_request(slwg_pkg::MODE_SCHED, 32'hFFFF_0000, '0, 64'd100, 64'd50);
		push_request(slwg_pkg::MODE_AUTH, slwg_pkg::SAT_TIME, 64'd50, '0, '0);
		push_request(slwg_pkg::MODE_AUTH, slwg_pkg::SAT_TIME, 64'd0, '0, '0);
		push_request(slwg_pkg::MODE_AUTH, slwg_pkg::SAT_TIME, 64'd1, '0, '0);
		push_request(slwg_pkg::MODE_SCHED, slwg_pkg::SAT_TIME, '0, 64'd100, 64'd10);
		push_request(slwg_pkg::MODE_AUTH, slwg_pkg::SAT_TIME, 64'd0, '0, '0);
		push_request(slwg_pkg::MODE_AUTH, 32'd5, 64'd0, '0, '0);
		push_request(slwg_pkg::MODE_ROLL, 32'd86398, '0, '0, '0);
		push_request(slwg_pkg::MODE_ROLL, 32'd86399, '0, '0, '0);
		push_request(slwg_pkg::MODE_AUTH, 32'd86399, 64'd10, '0, '0);

		// A schedule at time zero with no cooldown leaves nothing pending.
		configure(32'd0, 32'd0);
		push_request(slwg_pkg::MODE_SCHED, 32'd0, '0, 64'd7, 64'd7);
		push_request(slwg_pkg::MODE_AUTH, 32'd0, 64'd0, '0, '0);
		push_request(slwg_pkg::MODE_ROLL, 32'd12345, '0, '0, '0);
		push_request(slwg_pkg::MODE_QUERY, 32'd0, '0, '0, '0);
		clock_now = '0;

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: configure(slwg_pkg::SAT_TIME, 32'd0);
				1: configure(32'd0, slwg_pkg::SAT_TIME);
				2: configure(32'd1, 32'd1);
				default: configure($urandom_range(2, 60), $urandom_range(0, 20));
			endcase
			steady = (p % 3 == 2);
			for (int k = 0; k < 140; k++) begin
				if (k == 70) drain();
				random_request();
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

FILE: files.f
+incdir+hdl
hdl/slwg_pkg.sv
hdl/slwg_apb_regs.sv
hdl/slwg_core.sv
hdl/spend_limit_window_guard_unit.sv
sim/slwg_checker.sv
sim/tb_top.sv
